>>> design/assert_macros.svh
// assertion helpers used by udp_peer_connection_tracker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define AST_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

>>> design/uct_pkg.sv
`timescale 1ns / 1ps
package uct_pkg;

	// slot states
	typedef enum logic [1:0] {
		ST_FREE = 2'd0,
		ST_PEND = 2'd1,
		ST_CONN = 2'd2
	} slot_st_t;

	// operation codes
	localparam logic [2:0] OP_HDR     = 3'd0;
	localparam logic [2:0] OP_SWEEP   = 3'd1;
	localparam logic [2:0] OP_CONNECT = 3'd2;
	localparam logic [2:0] OP_LDISC   = 3'd3;
	localparam logic [2:0] OP_SEND    = 3'd4;

	// wire types as received
	localparam logic [7:0] WIRE_HELLO = 8'd0;
	localparam logic [7:0] WIRE_ACK   = 8'd1;
	localparam logic [7:0] WIRE_HB    = 8'd2;
	localparam logic [7:0] WIRE_DISC  = 8'd3;
	localparam logic [7:0] WIRE_DATA  = 8'd4;

	// wire types to transmit
	localparam logic [2:0] TX_HELLO = 3'd0;
	localparam logic [2:0] TX_ACK   = 3'd1;
	localparam logic [2:0] TX_HB    = 3'd2;
	localparam logic [2:0] TX_DISC  = 3'd3;
	localparam logic [2:0] TX_DATA  = 3'd4;

	// result actions
	localparam logic [2:0] A_CONN   = 3'd0;
	localparam logic [2:0] A_DISC   = 3'd1;
	localparam logic [2:0] A_DATA   = 3'd2;
	localparam logic [2:0] A_CTRL   = 3'd3;
	localparam logic [2:0] A_DTX    = 3'd4;
	localparam logic [2:0] A_STATUS = 3'd5;

	// register indexes
	localparam logic [1:0] CFG_IS_HOST = 2'd0;
	localparam logic [1:0] CFG_HB      = 2'd1;
	localparam logic [1:0] CFG_TO      = 2'd2;

	localparam logic [15:0] HB_RESET    = 16'd500;
	localparam logic [19:0] TO_RESET    = 20'd5000;
	localparam logic [31:0] PROTO_MAGIC = 32'h41434E50;
	localparam logic [15:0] HDR_BYTES   = 16'd8;
	localparam logic [3:0]  RES_CAP     = 4'd9;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  slot;
		logic [2:0]  tx_type;
		logic [7:0]  kind;
		logic [15:0] size;
		logic [31:0] ip;
		logic [15:0] port;
		logic        ok;
	} res_t;

	// item data broadcast to every cell
	typedef struct packed {
		logic        sweep;
		logic        bcast;
		logic [31:0] now;
		logic [15:0] hb;
		logic [19:0] to;
		logic [7:0]  kind;
		logic [15:0] size;
		logic [31:0] ip;
		logic [15:0] port;
	} cell_cmd_t;

	// write into one selected cell
	typedef struct packed {
		logic     st_en;
		slot_st_t st;
		logic     addr_en;
		logic     recv_en;
		logic     send_en;
		logic     send_zero;
	} cell_wr_t;

	// what a cell shows to the sequencer
	typedef struct packed {
		slot_st_t    st;
		logic [31:0] ip;
		logic [15:0] port;
		logic        match;
		logic        emit;
		logic        cnt_bit;
	} cell_stat_t;

endpackage

>>> design/udp_peer_connection_tracker.sv
`timescale 1ns / 1ps
// udp peer connection tracker
// input channel: in_valid/in_stall with one operation per transfer (received
// header, sweep, client connect, local disconnect, data send).
// output channel: out_valid/out_stall, one result per transfer; the final
// result of an operation carries last. an operation that yields nothing
// gives no transfer.
// config: cfg_we writes cfg_data into register cfg_index. the user must do
// so only while idle; the block does not enforce it. the item is registered,
// then decided in the decision state. header, connect, disconnect and unicast
// send then deliver their one or two results as the output register frees.
// sweep and broadcast pass a token down the row of MAX_PEERS slot cells, one
// cell per cycle, and a broadcast then adds its status. a new item is taken
// once the previous one has handed its last result to the output register.
// stall: a held output register freezes the token on the cell that wants to
// emit; cells with nothing to emit are passed at one per cycle regardless.
// reset: all slots free, is_host 0, interval 500, timeout 5000, output empty.
`include "assert_macros.svh"
module udp_peer_connection_tracker import uct_pkg::*; #(
	parameter int MAX_PEERS   = 8,
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic [31:0] addr_ip,
	input  logic [15:0] addr_port,
	input  logic [31:0] hdr_magic,
	input  logic [7:0]  hdr_type,
	input  logic [7:0]  msg_kind,
	input  logic [15:0] payload_size,
	input  logic [15:0] datagram_len,
	input  logic [2:0]  peer_index,
	input  logic        broadcast,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [2:0]  slot,
	output logic [2:0]  tx_type,
	output logic [7:0]  out_kind,
	output logic [15:0] out_size,
	output logic [31:0] dest_ip,
	output logic [15:0] dest_port,
	output logic        ok,
	output logic [3:0]  connected_count,
	output logic        last
);
	localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
	localparam int CW = $clog2(MAX_PEERS + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_EMIT = 5'b00100,
		S_WALK = 5'b01000,
		S_STAT = 5'b10000
	} fsm_t;

	function automatic logic [IW-1:0] enc(input logic [MAX_PEERS-1:0] oh);
		logic [IW-1:0] r;
		r = '0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			if (oh[i]) r = r | IW'(i);
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] popc(input logic [MAX_PEERS-1:0] v);
		logic [CW-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			c = c + CW'(v[i]);
		end
		return c;
	endfunction

	fsm_t        state_q;
	logic        is_host_q;
	logic [15:0] hb_q;
	logic [19:0] to_q;

	logic [2:0]  op_q;
	logic [31:0] now_q;
	logic [31:0] ip_q;
	logic [15:0] port_q;
	logic [31:0] magic_q;
	logic [7:0]  type_q;
	logic [7:0]  kind_q;
	logic [15:0] size_q;
	logic [15:0] len_q;
	logic [2:0]  peer_q;
	logic        bc_q;

	res_t        r0_q;
	res_t        r1_q;
	logic        two_q;
	logic        k_q;
	logic [3:0]  cnt_q;
	logic [3:0]  n_q;
	logic        any_q;

	logic        out_vld_q;
	res_t        out_q;
	logic        out_last_q;
	logic [3:0]  out_cnt_q;

	cell_cmd_t   cmd;
	cell_wr_t    dwr;
	cell_stat_t  stat_a [MAX_PEERS];
	res_t        res_a  [MAX_PEERS];
	logic [MAX_PEERS-1:0] go_v;
	logic [MAX_PEERS-1:0] tok_v;
	logic [MAX_PEERS-1:0] tin_v;
	logic [MAX_PEERS-1:0] match_v;
	logic [MAX_PEERS-1:0] free_v;
	logic [MAX_PEERS-1:0] conn_v;
	logic [MAX_PEERS-1:0] emit_v;
	logic [MAX_PEERS-1:0] cnt_v;
	logic [MAX_PEERS-1:0] sel_v;
	logic [MAX_PEERS-1:0] later_v;
	logic [MAX_PEERS-1:0] pm_v;
	logic [MAX_PEERS-1:0] pf_v;
	logic [MAX_PEERS-1:0] tsel;
	logic [MAX_PEERS-1:0] wsel;
	logic [MAX_PEERS-1:0] nconn;

	logic        in_acc;
	logic        out_free;
	logic        size_ok;
	logic        hdr_ok;
	logic        walk_op;
	logic        walk_start;
	logic        walk_put;
	logic        walk_last;
	logic        room;
	logic        has_m;
	logic        has_f;
	logic [IW-1:0] t_idx;
	logic [31:0] t_ip;
	logic [15:0] t_port;
	logic [1:0]  t_st;
	res_t        dres0;
	res_t        dres1;
	logic [1:0]  dn;
	logic [3:0]  dcnt;
	res_t        wres;
	logic [3:0]  wcnt;
	logic        out_put;
	res_t        nres;
	logic        nlast;
	logic [3:0]  ncnt;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & !in_stall;
	assign out_free = !out_vld_q | !out_stall;
	assign size_ok  = {16'b0, size_q} <= 32'(MAX_PAYLOAD);
	assign hdr_ok   = (len_q >= HDR_BYTES) && (magic_q == PROTO_MAGIC);
	assign walk_op  = (op_q == OP_SWEEP) || ((op_q == OP_SEND) && bc_q && size_ok);
	assign walk_start = (state_q == S_DEC) && walk_op;

	// shared command for the cell row
	always_comb begin
		cmd.sweep = (op_q == OP_SWEEP);
		cmd.bcast = (op_q == OP_SEND) && bc_q;
		cmd.now   = now_q;
		cmd.hb    = hb_q;
		cmd.to    = to_q;
		cmd.kind  = kind_q;
		cmd.size  = size_q;
		cmd.ip    = ip_q;
		cmd.port  = port_q;
	end

	// row of slot cells with the token handed down the chain
	for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign tin_v[g] = walk_start;
		end else begin : g_link
			assign tin_v[g] = go_v[g-1];
		end
		assign wsel[g] = tsel[g] && (state_q == S_DEC) && !walk_op;
		assign sel_v[g] = ({29'b0, peer_q} == 32'(g));

		uct_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.wr       (dwr),
			.wr_sel   (wsel[g]),
			.tok_in   (tin_v[g]),
			.out_free (out_free),
			.room     (room),
			.go       (go_v[g]),
			.tok      (tok_v[g]),
			.stat     (stat_a[g]),
			.res      (res_a[g])
		);

		assign match_v[g] = stat_a[g].match;
		assign free_v[g]  = (stat_a[g].st == ST_FREE);
		assign conn_v[g]  = (stat_a[g].st == ST_CONN);
		assign emit_v[g]  = stat_a[g].emit;
		assign cnt_v[g]   = stat_a[g].cnt_bit;
		assign later_v[g] = |(emit_v >> (g + 1));
	end

	// lowest matching and lowest free slot
	assign pm_v  = match_v & (~match_v + MAX_PEERS'(1));
	assign pf_v  = free_v & (~free_v + MAX_PEERS'(1));
	assign has_m = |match_v;
	assign has_f = |free_v;

	// target slot of a single-slot operation
	always_comb begin
		tsel = '0;
		case (op_q)
			OP_HDR: begin
				if (type_q == WIRE_ACK) tsel = MAX_PEERS'(1);
				else if (type_q == WIRE_HELLO && !has_m) tsel = pf_v;
				else tsel = pm_v;
			end
			OP_CONNECT: tsel = MAX_PEERS'(1);
			OP_LDISC:   tsel = is_host_q ? sel_v : MAX_PEERS'(1);
			OP_SEND:    tsel = sel_v;
			default:    tsel = '0;
		endcase
	end

	// read of the target slot
	always_comb begin
		t_ip   = '0;
		t_port = '0;
		t_st   = '0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			t_ip   = t_ip | ({32{tsel[i]}} & stat_a[i].ip);
			t_port = t_port | ({16{tsel[i]}} & stat_a[i].port);
			t_st   = t_st | ({2{tsel[i]}} & stat_a[i].st);
		end
		t_idx = enc(tsel);
	end

	// single-slot decision
	always_comb begin
		dres0 = '0;
		dres1 = '0;
		dn    = 2'd0;
		dwr   = '0;
		dwr.st = ST_FREE;
		case (op_q)
			OP_HDR: begin
				if (hdr_ok) begin
					case (type_q)
						WIRE_HELLO: begin
							if (is_host_q && has_m) begin
								dwr.recv_en   = 1'b1;
								dres0.action  = A_CTRL;
								dres0.slot    = 3'(t_idx);
								dres0.tx_type = TX_ACK;
								dres0.ip      = ip_q;
								dres0.port    = port_q;
								dn            = 2'd1;
							end else if (is_host_q && has_f) begin
								dwr.st_en     = 1'b1;
								dwr.st        = ST_CONN;
								dwr.addr_en   = 1'b1;
								dwr.recv_en   = 1'b1;
								dwr.send_en   = 1'b1;
								dwr.send_zero = 1'b1;
								dres0.action  = A_CONN;
								dres0.slot    = 3'(t_idx);
								dres1.action  = A_CTRL;
								dres1.slot    = 3'(t_idx);
								dres1.tx_type = TX_ACK;
								dres1.ip      = ip_q;
								dres1.port    = port_q;
								dn            = 2'd2;
							end
						end
						WIRE_ACK: begin
							if (!is_host_q && match_v[0] && stat_a[0].st == ST_PEND) begin
								dwr.st_en    = 1'b1;
								dwr.st       = ST_CONN;
								dwr.recv_en  = 1'b1;
								dres0.action = A_CONN;
								dn           = 2'd1;
							end
						end
						WIRE_HB: begin
							dwr.recv_en = has_m;
						end
						WIRE_DISC: begin
							if (has_m) begin
								dwr.st_en    = 1'b1;
								dwr.st       = ST_FREE;
								dres0.action = A_DISC;
								dres0.slot   = 3'(t_idx);
								dn           = 2'd1;
							end
						end
						WIRE_DATA: begin
							if (has_m) begin
								dwr.recv_en = 1'b1;
								if (size_ok && ({1'b0, size_q} + 17'(HDR_BYTES) <= {1'b0, len_q}))
								begin
									dres0.action = A_DATA;
									dres0.slot   = 3'(t_idx);
									dres0.kind   = kind_q;
									dres0.size   = size_q;
									dn           = 2'd1;
								end
							end
						end
						default: dn = 2'd0;
					endcase
				end
			end
			OP_CONNECT: begin
				if (!is_host_q) begin
					dwr.st_en     = 1'b1;
					dwr.st        = ST_PEND;
					dwr.addr_en   = 1'b1;
					dwr.recv_en   = 1'b1;
					dwr.send_en   = 1'b1;
					dres0.action  = A_CTRL;
					dres0.tx_type = TX_HELLO;
					dres0.ip      = ip_q;
					dres0.port    = port_q;
					dn            = 2'd1;
				end
			end
			OP_LDISC: begin
				if ((|tsel) && t_st != ST_FREE) begin
					dwr.st_en     = 1'b1;
					dwr.st        = ST_FREE;
					dres0.action  = A_CTRL;
					dres0.slot    = 3'(t_idx);
					dres0.tx_type = TX_DISC;
					dres0.ip      = t_ip;
					dres0.port    = t_port;
					dn            = 2'd1;
				end
			end
			OP_SEND: begin
				if (!bc_q && size_ok && (|tsel) && t_st == ST_CONN) begin
					dwr.send_en   = 1'b1;
					dres0.action  = A_DTX;
					dres0.slot    = 3'(t_idx);
					dres0.tx_type = TX_DATA;
					dres0.kind    = kind_q;
					dres0.size    = size_q;
					dres0.ip      = t_ip;
					dres0.port    = t_port;
					dres1.action  = A_STATUS;
					dres1.slot    = peer_q;
					dres1.ok      = 1'b1;
					dn            = 2'd2;
				end else begin
					dres0.action = A_STATUS;
					dres0.slot   = bc_q ? 3'd0 : peer_q;
					dn           = 2'd1;
				end
			end
			default: dn = 2'd0;
		endcase
	end

	// connected count after a single-slot operation
	always_comb begin
		nconn = conn_v;
		if (dwr.st_en) begin
			nconn = (conn_v & ~tsel) | (tsel & {MAX_PEERS{dwr.st == ST_CONN}});
		end
		dcnt = 4'(popc(nconn));
	end

	// result offered by the token holder
	always_comb begin
		wres = '0;
		for (int i = 0; i < MAX_PEERS; i++) begin
			if (tok_v[i]) wres = wres | res_a[i];
		end
		wres.slot = 3'(enc(tok_v));
		room      = n_q < (cmd.bcast ? (RES_CAP - 4'd1) : RES_CAP);
		walk_put  = (state_q == S_WALK) && (|(go_v & emit_v)) && room;
		walk_last = cmd.sweep && (!(|(tok_v & later_v)) || n_q == (RES_CAP - 4'd1));
		wcnt      = 4'(popc(cnt_v));
	end

	// next transfer into the output register
	always_comb begin
		out_put = 1'b0;
		nres    = '0;
		nlast   = 1'b0;
		ncnt    = '0;
		case (state_q)
			S_EMIT: begin
				out_put = out_free;
				nres    = k_q ? r1_q : r0_q;
				nlast   = k_q | !two_q;
				ncnt    = cnt_q;
			end
			S_WALK: begin
				out_put = walk_put;
				nres    = wres;
				nlast   = walk_last;
				ncnt    = wcnt;
			end
			S_STAT: begin
				out_put     = out_free;
				nres.action = A_STATUS;
				nres.ok     = any_q;
				nlast       = 1'b1;
				ncnt        = wcnt;
			end
			default: out_put = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_host_q <= 1'b0;
			hb_q      <= HB_RESET;
			to_q      <= TO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IS_HOST: is_host_q <= cfg_data[0];
				CFG_HB:      hb_q      <= cfg_data[15:0];
				CFG_TO:      to_q      <= cfg_data;
				default:     is_host_q <= is_host_q;
			endcase
		end
	end

	// item capture and registered decision results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= opcode;
			now_q   <= now_ms;
			ip_q    <= addr_ip;
			port_q  <= addr_port;
			magic_q <= hdr_magic;
			type_q  <= hdr_type;
			kind_q  <= msg_kind;
			size_q  <= payload_size;
			len_q   <= datagram_len;
			peer_q  <= peer_index;
			bc_q    <= broadcast;
		end
		if (state_q == S_DEC) begin
			r0_q  <= dres0;
			r1_q  <= dres1;
			two_q <= (dn == 2'd2);
			cnt_q <= dcnt;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= 1'b0;
			n_q     <= '0;
			any_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_DEC;
				end
				S_DEC: begin
					k_q   <= 1'b0;
					n_q   <= '0;
					any_q <= 1'b0;
					if (walk_op) state_q <= S_WALK;
					else if (dn == 2'd0) state_q <= S_IDLE;
					else state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						k_q <= 1'b1;
						if (k_q || !two_q) state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (|(go_v & emit_v)) any_q <= 1'b1;
					if (walk_put) n_q <= n_q + 4'd1;
					if (go_v[MAX_PEERS-1]) state_q <= cmd.bcast ? S_STAT : S_IDLE;
				end
				S_STAT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
			out_cnt_q  <= '0;
		end else begin
			out_vld_q <= out_put | (out_vld_q & out_stall);
			if (out_put) begin
				out_q      <= nres;
				out_last_q <= nlast;
				out_cnt_q  <= ncnt;
			end
		end
	end

	assign out_valid       = out_vld_q;
	assign action          = out_q.action;
	assign slot            = out_q.slot;
	assign tx_type         = out_q.tx_type;
	assign out_kind        = out_q.kind;
	assign out_size        = out_q.size;
	assign dest_ip         = out_q.ip;
	assign dest_port       = out_q.port;
	assign ok              = out_q.ok;
	assign connected_count = out_cnt_q;
	assign last            = out_last_q;

	// at most one cell holds the token
	`AST_ALWAYS(a_tok_onehot, clk, arst_n, $onehot0(tok_v))
	// the token only moves during a walk
	`AST_IMPLY(a_tok_walk, clk, arst_n, (|tok_v), state_q == S_WALK)
	// emitted count never passes the per-item cap
	`AST_ALWAYS(a_cap, clk, arst_n, n_q <= RES_CAP)

endmodule

>>> design/uct_cell.sv
`timescale 1ns / 1ps
module uct_cell import uct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  cell_wr_t   wr,
	input  logic       wr_sel,
	input  logic       tok_in,
	input  logic       out_free,
	input  logic       room,
	output logic       go,
	output logic       tok,
	output cell_stat_t stat,
	output res_t       res
);
	slot_st_t    st_q;
	logic [31:0] ip_q;
	logic [15:0] port_q;
	logic [31:0] recv_q;
	logic [31:0] send_q;
	logic        tok_q;

	logic        pend;
	logic        conn;
	logic        hb_due;
	logic        to_due;
	logic        emit;
	logic        send_upd;
	logic [31:0] dsend;
	logic [31:0] drecv;

	// local sweep and broadcast decisions
	always_comb begin
		pend     = (st_q == ST_PEND);
		conn     = (st_q == ST_CONN);
		dsend    = cmd.now - send_q;
		drecv    = cmd.now - recv_q;
		hb_due   = dsend > {16'b0, cmd.hb};
		to_due   = drecv > {12'b0, cmd.to};
		emit     = cmd.sweep ? ((pend & hb_due) | (conn & (to_due | hb_due)))
		                     : (cmd.bcast & conn);
		send_upd = cmd.sweep ? ((pend & hb_due) | (conn & !to_due & hb_due))
		                     : (cmd.bcast & conn);
		go       = tok_q & (!(emit & room) | out_free);
	end

	// result offered while the token sits here
	always_comb begin
		res = '0;
		if (emit) begin
			if (cmd.sweep) begin
				if (pend) begin
					res.action  = A_CTRL;
					res.tx_type = TX_HELLO;
					res.ip      = ip_q;
					res.port    = port_q;
				end else if (to_due) begin
					res.action = A_DISC;
				end else begin
					res.action  = A_CTRL;
					res.tx_type = TX_HB;
					res.ip      = ip_q;
					res.port    = port_q;
				end
			end else begin
				res.action  = A_DTX;
				res.tx_type = TX_DATA;
				res.kind    = cmd.kind;
				res.size    = cmd.size;
				res.ip      = ip_q;
				res.port    = port_q;
			end
		end
	end

	always_comb begin
		stat.st      = st_q;
		stat.ip      = ip_q;
		stat.port    = port_q;
		stat.match   = (st_q != ST_FREE) && (ip_q == cmd.ip) && (port_q == cmd.port);
		stat.emit    = emit;
		stat.cnt_bit = conn & !(cmd.sweep & to_due);
		tok          = tok_q;
	end

	// token and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			st_q  <= ST_FREE;
		end else begin
			tok_q <= tok_in | (tok_q & !go);
			if (wr_sel && wr.st_en) begin
				st_q <= wr.st;
			end else if (go && cmd.sweep && conn && to_due) begin
				st_q <= ST_FREE;
			end
		end
	end

	// address and times
	always_ff @(posedge clk) begin
		if (wr_sel && wr.addr_en) begin
			ip_q   <= cmd.ip;
			port_q <= cmd.port;
		end
		if (wr_sel && wr.recv_en) begin
			recv_q <= cmd.now;
		end
		if (wr_sel && wr.send_en) begin
			send_q <= wr.send_zero ? 32'd0 : cmd.now;
		end else if (go && send_upd) begin
			send_q <= cmd.now;
		end
	end

endmodule

>>> bench/uct_checker.sv
`timescale 1ns / 1ps
module uct_checker import uct_pkg::*; #(
	parameter int PEERS       = 8,
	parameter int PAYLOAD_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] now_ms,
	input  logic [31:0] addr_ip,
	input  logic [15:0] addr_port,
	input  logic [31:0] hdr_magic,
	input  logic [7:0]  hdr_type,
	input  logic [7:0]  msg_kind,
	input  logic [15:0] payload_size,
	input  logic [15:0] datagram_len,
	input  logic [2:0]  peer_index,
	input  logic        broadcast,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  action,
	input  logic [2:0]  slot,
	input  logic [2:0]  tx_type,
	input  logic [7:0]  out_kind,
	input  logic [15:0] out_size,
	input  logic [31:0] dest_ip,
	input  logic [15:0] dest_port,
	input  logic        ok,
	input  logic [3:0]  connected_count,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		res_t       r;
		logic [3:0] cnt;
		logic       lst;
	} peer_result_t;

	// shadow of the peer table and registers
	slot_st_t    peer_st[PEERS];
	logic [31:0] peer_ip[PEERS];
	logic [15:0] peer_port[PEERS];
	logic [31:0] heard_ms[PEERS];
	logic [31:0] sent_ms[PEERS];
	logic        host_mode;
	logic [15:0] hb_ms;
	logic [19:0] to_ms;

	peer_result_t awaited_q[$];
	res_t         step_q[$];

	assign outstanding = awaited_q.size();

	function automatic void emit(input logic [2:0] a, input int s, input logic [2:0] tx,
			input logic [7:0] k, input logic [15:0] sz, input logic [31:0] ip_,
			input logic [15:0] pt, input logic o, input int cap);
		res_t r;
		if (step_q.size() >= cap)
			return;
		r.action = a;
		r.slot = s[2:0];
		r.tx_type = tx;
		r.kind = k;
		r.size = sz;
		r.ip = ip_;
		r.port = pt;
		r.ok = o;
		step_q.push_back(r);
	endfunction

	function automatic int lookup_peer(input logic [31:0] ip_, input logic [15:0] pt);
		for (int i = 0; i < PEERS; i++)
			if (peer_st[i] != ST_FREE && peer_ip[i] == ip_ && peer_port[i] == pt)
				return i;
		return -1;
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < PEERS; i++)
			if (peer_st[i] == ST_FREE)
				return i;
		return -1;
	endfunction

	function automatic void send_data(input int i, input logic [7:0] k,
			input logic [15:0] sz, input logic [31:0] now);
		emit(A_DTX, i, TX_DATA, k, sz, peer_ip[i], peer_port[i], 1'b0, RES_CAP - 1);
		sent_ms[i] = now;
	endfunction

	// apply one operation to the shadow table and queue its results
	function automatic void track_op();
		int p;
		int cnt;
		logic [31:0] now;
		logic sent;
		now = now_ms;
		sent = 1'b0;
		cnt = 0;
		step_q.delete();
		case (opcode)
			OP_HDR: begin
				if (datagram_len >= HDR_BYTES && hdr_magic == PROTO_MAGIC) begin
					p = lookup_peer(addr_ip, addr_port);
					case (hdr_type)
						WIRE_HELLO: begin
							if (host_mode) begin
								if (p < 0) begin
									p = lowest_free();
									if (p >= 0) begin
										peer_st[p] = ST_CONN;
										peer_ip[p] = addr_ip;
										peer_port[p] = addr_port;
										heard_ms[p] = now;
										sent_ms[p] = '0;
										emit(A_CONN, p, 0, 0, 0, 0, 0, 0, RES_CAP);
									end
								end else
									heard_ms[p] = now;
								if (p >= 0)
									emit(A_CTRL, p, TX_ACK, 0, 0, addr_ip, addr_port, 0, RES_CAP);
							end
						end
						WIRE_ACK: begin
							if (!host_mode && peer_st[0] == ST_PEND && peer_ip[0] == addr_ip
									&& peer_port[0] == addr_port) begin
								peer_st[0] = ST_CONN;
								heard_ms[0] = now;
								emit(A_CONN, 0, 0, 0, 0, 0, 0, 0, RES_CAP);
							end
						end
						WIRE_HB: begin
							if (p >= 0)
								heard_ms[p] = now;
						end
						WIRE_DISC: begin
							if (p >= 0) begin
								peer_st[p] = ST_FREE;
								emit(A_DISC, p, 0, 0, 0, 0, 0, 0, RES_CAP);
							end
						end
						WIRE_DATA: begin
							if (p >= 0) begin
								heard_ms[p] = now;
								if (payload_size <= PAYLOAD_MAX
										&& 32'(payload_size) + 32'd8 <= 32'(datagram_len))
									emit(A_DATA, p, 0, msg_kind, payload_size, 0, 0, 0, RES_CAP);
							end
						end
						default: ;
					endcase
				end
			end
			OP_SWEEP: begin
				for (int i = 0; i < PEERS; i++) begin
					if (peer_st[i] == ST_PEND) begin
						if (32'(now - sent_ms[i]) > 32'(hb_ms)) begin
							emit(A_CTRL, i, TX_HELLO, 0, 0, peer_ip[i], peer_port[i], 0, RES_CAP);
							sent_ms[i] = now;
						end
					end else if (peer_st[i] == ST_CONN) begin
						if (32'(now - heard_ms[i]) > 32'(to_ms)) begin
							peer_st[i] = ST_FREE;
							emit(A_DISC, i, 0, 0, 0, 0, 0, 0, RES_CAP);
						end else if (32'(now - sent_ms[i]) > 32'(hb_ms)) begin
							emit(A_CTRL, i, TX_HB, 0, 0, peer_ip[i], peer_port[i], 0, RES_CAP);
							sent_ms[i] = now;
						end
					end
				end
			end
			OP_CONNECT: begin
				if (!host_mode) begin
					peer_st[0] = ST_PEND;
					peer_ip[0] = addr_ip;
					peer_port[0] = addr_port;
					heard_ms[0] = now;
					sent_ms[0] = now;
					emit(A_CTRL, 0, TX_HELLO, 0, 0, addr_ip, addr_port, 0, RES_CAP);
				end
			end
			OP_LDISC: begin
				p = host_mode ? int'(peer_index) : 0;
				if (p < PEERS && peer_st[p] != ST_FREE) begin
					emit(A_CTRL, p, TX_DISC, 0, 0, peer_ip[p], peer_port[p], 0, RES_CAP);
					peer_st[p] = ST_FREE;
				end
			end
			OP_SEND: begin
				if (payload_size <= PAYLOAD_MAX) begin
					if (broadcast) begin
						for (int i = 0; i < PEERS; i++)
							if (peer_st[i] == ST_CONN) begin
								send_data(i, msg_kind, payload_size, now);
								sent = 1'b1;
							end
					end else if (int'(peer_index) < PEERS && peer_st[peer_index] == ST_CONN) begin
						send_data(int'(peer_index), msg_kind, payload_size, now);
						sent = 1'b1;
					end
				end
				emit(A_STATUS, broadcast ? 0 : int'(peer_index), 0, 0, 0, 0, 0, sent, RES_CAP);
			end
			default: ;
		endcase
		for (int i = 0; i < PEERS; i++)
			if (peer_st[i] == ST_CONN)
				cnt++;
		foreach (step_q[i]) begin
			peer_result_t e;
			e.r = step_q[i];
			e.cnt = cnt[3:0];
			e.lst = (i == step_q.size() - 1);
			awaited_q.push_back(e);
		end
	endfunction

	// compare output transfers, then track input transfers and register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PEERS; i++) begin
				peer_st[i] = ST_FREE;
				peer_ip[i] = '0;
				peer_port[i] = '0;
				heard_ms[i] = '0;
				sent_ms[i] = '0;
			end
			host_mode = 1'b0;
			hb_ms = HB_RESET;
			to_ms = TO_RESET;
			awaited_q.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				peer_result_t got;
				got.r.action = action;
				got.r.slot = slot;
				got.r.tx_type = tx_type;
				got.r.kind = out_kind;
				got.r.size = out_size;
				got.r.ip = dest_ip;
				got.r.port = dest_port;
				got.r.ok = ok;
				got.cnt = connected_count;
				got.lst = last;
				if (awaited_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result transfer %p", $realtime, got);
					mismatches++;
				end else begin
					peer_result_t exp_r;
					exp_r = awaited_q.pop_front();
					if (got !== exp_r) begin
						if (mismatches < 10)
							$display("%0t: result mismatch\n  expected %p\n  actual   %p",
								$realtime, exp_r, got);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_IS_HOST: host_mode = cfg_data[0];
					CFG_HB:      hb_ms = cfg_data[15:0];
					CFG_TO:      to_ms = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				track_op();
		end
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import uct_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 24;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic [31:0] now_ms;
	logic [31:0] addr_ip;
	logic [15:0] addr_port;
	logic [31:0] hdr_magic;
	logic [7:0]  hdr_type;
	logic [7:0]  msg_kind;
	logic [15:0] payload_size;
	logic [15:0] datagram_len;
	logic [2:0]  peer_index;
	logic        broadcast;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  action;
	logic [2:0]  slot;
	logic [2:0]  tx_type;
	logic [7:0]  out_kind;
	logic [15:0] out_size;
	logic [31:0] dest_ip;
	logic [15:0] dest_port;
	logic        ok;
	logic [3:0]  connected_count;
	logic        last;
	int          mismatches;
	int          outstanding;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] magic;
		logic [7:0]  wtype;
		logic [7:0]  kind;
		logic [15:0] size;
		logic [15:0] len;
		logic [2:0]  idx;
		logic        bc;
	} op_item_t;

	logic [31:0] clock_ms;
	int          hb_cur;
	int          to_cur;
	logic        host_cur;
	int          burst_left;
	logic [31:0] pool_ip[10];
	logic [15:0] pool_port[10];

	udp_peer_connection_tracker u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.now_ms(now_ms), .addr_ip(addr_ip), .addr_port(addr_port), .hdr_magic(hdr_magic),
		.hdr_type(hdr_type), .msg_kind(msg_kind), .payload_size(payload_size),
		.datagram_len(datagram_len), .peer_index(peer_index), .broadcast(broadcast),
		.out_valid(out_valid), .out_stall(out_stall), .action(action), .slot(slot),
		.tx_type(tx_type), .out_kind(out_kind), .out_size(out_size), .dest_ip(dest_ip),
		.dest_port(dest_port), .ok(ok), .connected_count(connected_count), .last(last)
	);

	uct_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.now_ms(now_ms), .addr_ip(addr_ip), .addr_port(addr_port), .hdr_magic(hdr_magic),
		.hdr_type(hdr_type), .msg_kind(msg_kind), .payload_size(payload_size),
		.datagram_len(datagram_len), .peer_index(peer_index), .broadcast(broadcast),
		.out_valid(out_valid), .out_stall(out_stall), .action(action), .slot(slot),
		.tx_type(tx_type), .out_kind(out_kind), .out_size(out_size), .dest_ip(dest_ip),
		.dest_port(dest_port), .ok(ok), .connected_count(connected_count), .last(last),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stall, switching between free flow, random and long holds
	int stall_mode;
	int stall_left;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 150);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= ($urandom_range(0, 5) == 0) ? ~out_stall : out_stall;
		endcase
	end

	// watchdog on cycles without any transfer
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one input transfer, with bursts and gaps on the sender side
	task automatic issue(input op_item_t o);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 6);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= o.op;
		now_ms <= clock_ms;
		addr_ip <= o.ip;
		addr_port <= o.port;
		hdr_magic <= o.magic;
		hdr_type <= o.wtype;
		msg_kind <= o.kind;
		payload_size <= o.size;
		datagram_len <= o.len;
		peer_index <= o.idx;
		broadcast <= o.bc;
		do @(posedge clk); while (in_stall);
	endtask

	// hold input until every result is out, then let the block go idle
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one register write; the caller drops the enable after the last one
	task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(input logic h, input int hb, input int to);
		settle();
		write_reg(CFG_IS_HOST, {19'd0, h});
		write_reg(CFG_HB, 20'(hb));
		write_reg(CFG_TO, 20'(to));
		cfg_we <= 1'b0;
		host_cur = h;
		hb_cur = hb;
		to_cur = to;
	endtask

	function automatic op_item_t noise_item();
		op_item_t o;
		o.op = 3'($urandom_range(0, 4));
		o.ip = $urandom();
		o.port = 16'($urandom());
		o.magic = ($urandom_range(0, 1) == 0) ? PROTO_MAGIC : $urandom();
		o.wtype = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom());
		o.kind = 8'($urandom());
		o.size = 16'($urandom());
		o.len = 16'($urandom());
		o.idx = 3'($urandom());
		o.bc = 1'($urandom());
		return o;
	endfunction

	function automatic op_item_t hdr_item(input int pi, input logic [7:0] wt);
		op_item_t o;
		o = noise_item();
		o.op = OP_HDR;
		o.ip = pool_ip[pi];
		o.port = pool_port[pi];
		o.magic = PROTO_MAGIC;
		o.wtype = wt;
		o.size = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
		o.len = 16'(o.size + 16'd8 + 16'($urandom_range(0, 2)) - 16'($urandom_range(0, 1)));
		return o;
	endfunction

	function automatic op_item_t simple_item(input logic [2:0] op, input int pi,
			input logic [2:0] idx, input logic bc, input logic [15:0] sz);
		op_item_t o;
		o = noise_item();
		o.op = op;
		o.ip = pool_ip[pi];
		o.port = pool_port[pi];
		o.idx = idx;
		o.bc = bc;
		o.size = sz;
		return o;
	endfunction

	task automatic tick(input int step);
		clock_ms = clock_ms + 32'(step);
	endtask

	// time moves by steps scaled to the current interval and timeout, or jumps to a random value
	task automatic wander();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: tick($urandom_range(0, hb_cur));
			5, 6, 7:       tick($urandom_range(0, hb_cur * 3));
			8:             tick($urandom_range(0, to_cur + to_cur / 2));
			default:       clock_ms = $urandom();
		endcase
	endtask

	task automatic random_item();
		int r;
		int pi;
		r = $urandom_range(0, 99);
		pi = $urandom_range(0, 9);
		wander();
		if (r < 25)
			issue(host_cur ? hdr_item(pi, WIRE_HELLO)
				: simple_item(OP_CONNECT, $urandom_range(0, 2), 0, 0, 0));
		else if (r < 35)
			issue(hdr_item(host_cur ? pi : $urandom_range(0, 2), WIRE_ACK));
		else if (r < 50)
			issue(hdr_item(pi, WIRE_DATA));
		else if (r < 58)
			issue(hdr_item(pi, WIRE_HB));
		else if (r < 63)
			issue(hdr_item(pi, WIRE_DISC));
		else if (r < 75)
			issue(simple_item(OP_SWEEP, pi, 0, 0, 0));
		else if (r < 87)
			issue(simple_item(OP_SEND, pi, 3'($urandom()), 1'($urandom()),
				($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024))));
		else if (r < 92)
			issue(simple_item(OP_LDISC, pi, 3'($urandom()), 0, 0));
		else
			issue(noise_item());
	endtask

	initial begin
		op_item_t o;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IS_HOST;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_HDR;
		now_ms = '0;
		addr_ip = '0;
		addr_port = '0;
		hdr_magic = '0;
		hdr_type = '0;
		msg_kind = '0;
		payload_size = '0;
		datagram_len = '0;
		peer_index = '0;
		broadcast = 1'b0;
		out_stall = 1'b0;
		stall_mode = 0;
		stall_left = 0;
		quiet_cycles = 0;
		burst_left = 0;
		host_cur = 1'b0;
		hb_cur = 500;
		to_cur = 5000;
		clock_ms = 32'hFFFF_F000;
		pool_ip[0] = 32'hFFFF_FFFF;
		pool_port[0] = 16'hFFFF;
		pool_ip[1] = '0;
		pool_port[1] = '0;
		for (int i = 2; i < 10; i++) begin
			pool_ip[i] = $urandom();
			pool_port[i] = 16'($urandom());
		end
		pool_ip[3] = pool_ip[2];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// client side at reset settings
		issue(simple_item(OP_CONNECT, 0, 0, 0, 0));
		issue(hdr_item(1, WIRE_ACK));
		issue(hdr_item(0, WIRE_ACK));
		issue(hdr_item(1, WIRE_HELLO));
		o = hdr_item(0, WIRE_DATA);
		o.kind = 8'hFF;
		o.size = 16'd1024;
		o.len = 16'd1032;
		issue(o);
		o.size = 16'd1025;
		o.len = 16'hFFFF;
		issue(o);
		o.size = 16'd10;
		o.len = 16'd17;
		issue(o);
		o = hdr_item(0, WIRE_DISC);
		o.len = 16'd7;
		issue(o);
		o.len = 16'd8;
		o.magic = ~PROTO_MAGIC;
		issue(o);
		issue(hdr_item(0, 8'd200));
		issue(hdr_item(0, WIRE_HB));
		tick(501);
		issue(simple_item(OP_SWEEP, 0, 0, 0, 0));
		issue(simple_item(OP_SEND, 0, 0, 0, 16'd0));
		issue(simple_item(OP_SEND, 0, 3'd7, 0, 16'd5));
		issue(simple_item(OP_SEND, 0, 3'd5, 1, 16'd1024));
		issue(simple_item(OP_SEND, 0, 0, 0, 16'hFFFF));
		tick(5001);
		issue(simple_item(OP_SWEEP, 0, 0, 0, 0));
		issue(simple_item(OP_SEND, 0, 0, 1, 16'd3));
		issue(simple_item(OP_CONNECT, 1, 0, 0, 0));
		tick(600);
		issue(simple_item(OP_SWEEP, 0, 0, 0, 0));
		issue(simple_item(OP_LDISC, 0, 3'd6, 0, 0));
		issue(simple_item(OP_LDISC, 0, 3'd6, 0, 0));

		// host: fill the table past full, then tear down
		configure(1'b1, 500, 5000);
		for (int i = 0; i < 10; i++)
			issue(hdr_item(i, WIRE_HELLO));
		issue(simple_item(OP_SEND, 0, 0, 1, 16'd64));
		issue(hdr_item(4, WIRE_DISC));
		issue(simple_item(OP_LDISC, 0, 3'd7, 0, 0));
		issue(simple_item(OP_LDISC, 0, 3'd7, 0, 0));
		issue(simple_item(OP_CONNECT, 5, 0, 0, 0));

		// random phases across register settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: configure(1'b1, 500, 5000);
				1: configure(1'b0, 1, 1);
				2: configure(1'b1, 65535, 1000000);
				3: configure(1'b0, 300, 2000);
				4: configure(1'b1, 1, 1000000);
				5: configure(1'b1, 65535, 1);
				default: configure(1'b0, 65535, 1000000);
			endcase
			for (int n = 0; n < 60; n++)
				random_item();
		end

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
